// File: rtl/core/lpfs_pkg.sv
// Shared constants and payload types for the least-prime-factor sieve factorizer.
package lpfs_pkg;

	localparam int MAX_LIMIT   = 16384;
	localparam int PRIME_SLOTS = 1900;
	localparam int MAX_RES     = 5;

	localparam int NUM_W = $clog2(MAX_LIMIT);
	localparam int LIM_W = NUM_W + 1;
	localparam int CNT_W = $clog2(PRIME_SLOTS + 1);
	localparam int PL_AW = $clog2(PRIME_SLOTS);
	localparam int EXP_W = 4;
	localparam int RES_W = $clog2(MAX_RES);
	localparam int PROD_W = LIM_W + NUM_W;

	typedef enum logic {
		MODE_BUILD = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [LIM_W-1:0] lim_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [EXP_W-1:0] exp_t;

endpackage

// File: rtl/core/lpfs_in_if.sv
// Command channel: valid/ready with mode and number.
interface lpfs_in_if;
	import lpfs_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	logic [NUM_W-1:0] number;

	modport source (output valid, mode, number, input ready);
	modport sink (input valid, mode, number, output ready);
endinterface

// File: rtl/core/lpfs_out_if.sv
// Result channel: valid/ready with one factor result.
interface lpfs_out_if;
	import lpfs_pkg::*;

	logic valid;
	logic ready;
	logic [NUM_W-1:0] prime_factor;
	logic [EXP_W-1:0] exponent;
	logic [NUM_W-1:0] least_factor;
	logic prime_flag;
	logic [CNT_W-1:0] prime_count;
	logic error;
	logic last;

	modport source (output valid, prime_factor, exponent, least_factor, prime_flag,
		prime_count, error, last, input ready);
	modport sink (input valid, prime_factor, exponent, least_factor, prime_flag,
		prime_count, error, last, output ready);
endinterface

// File: rtl/core/lpfs_div.sv
// Restoring divider, one quotient bit per cycle.
module lpfs_div
	import lpfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  num_t dividend,
	input  num_t divisor,
	output logic done,
	output num_t quotient
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	num_t a_q;
	num_t r_q;
	logic [STEP_W-1:0] step_q;
	logic done_q;
	logic [NUM_W:0] rs;
	logic fits;

	assign rs = {r_q, a_q[NUM_W-1]};
	assign fits = rs >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(NUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			r_q <= '0;
		end else if (step_q != '0) begin
			r_q <= fits ? NUM_W'(rs - {1'b0, divisor}) : NUM_W'(rs);
			a_q <= {a_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = a_q;

endmodule

// File: rtl/core/least_prime_factor_sieve_factorizer.sv
// Least-prime-factor sieve (linear sieve) and factorizer, top level.
//
// One item is handled at a time; cmd.ready is high only while the sequencer is idle.
// A build item (mode 0) first sweeps the whole least-prime-factor memory to zero, one
// entry a cycle, then walks i = 2 .. limit-1: each i reads and checks its table entry,
// then tries listed primes against i in turn (each composite it marks, and at most
// one try that ends the walk for that i), paced by the single read ports of the table
// and the prime list and the one 15x14 multiplier. Then one result with the prime
// count. A query item (mode 1) reads the table for n, then for every prime factor
// occurrence runs the restoring divider and rereads the table; it emits one result
// per distinct prime, ascending, and a single result with no factor for n below 2.
// A query before any build, or for a number not below limit, gives one result with
// error set. The output register lets the next command be taken while the final
// result of the previous one still waits; the sequencer stalls only when it has a
// further result to emit while the one before it has not been taken.
module least_prime_factor_sieve_factorizer
	import lpfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	lpfs_in_if.sink cmd,
	lpfs_out_if.source res
);

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_BRD, S_BCHK, S_BPL, S_BPW, S_BMUL, S_BCMP,
		S_QRD, S_QFIRST, S_QLOOP, S_QDIV, S_QNRD, S_QNV, S_EMIT
	} state_t;

	state_t state_q;

	// Memories
	num_t ft_mem [MAX_LIMIT];
	num_t pl_mem [PRIME_SLOTS];
	num_t ft_rd_q;
	num_t pl_rd_q;
	num_t ft_raddr;
	num_t ft_waddr;
	num_t ft_wdata;
	logic ft_we;
	logic pl_we;

	// Configuration and sieve state
	lim_t limit_q;
	lim_t lim;
	cnt_t pc_q;
	logic built_q;

	// Sequencer registers
	lim_t i_q;
	num_t lpf_q;
	cnt_t k_q;
	num_t j_q;
	logic [PROD_W-1:0] m_q;
	num_t n_q;
	num_t v_q;
	num_t pf_q;
	exp_t ex_q;
	num_t lf_q;
	logic ip_q;
	logic [RES_W-1:0] rc_q;

	// Pending result
	num_t pr_pf_q;
	exp_t pr_ex_q;
	num_t pr_lf_q;
	logic pr_ip_q;
	logic pr_err_q;
	logic pr_last_q;

	// Output register
	logic ov_q;
	logic out_free;
	logic emit_go;

	// Divider
	logic div_start;
	logic div_done;
	num_t div_quo;

	assign lim = (limit_q > lim_t'(MAX_LIMIT)) ? lim_t'(MAX_LIMIT) : limit_q;
	assign out_free = !ov_q || res.ready;
	assign emit_go = (state_q == S_EMIT) && out_free;
	assign cmd.ready = (state_q == S_IDLE);
	assign div_start = (state_q == S_QLOOP) && (n_q > num_t'(1)) && (v_q == pf_q);

	lpfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (pf_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Table port control
	always_comb begin
		ft_raddr = n_q;
		ft_waddr = i_q[NUM_W-1:0];
		ft_wdata = '0;
		ft_we = 1'b0;
		pl_we = 1'b0;
		unique case (state_q)
			S_BRD: ft_raddr = i_q[NUM_W-1:0];
			S_CLR: ft_we = 1'b1;
			S_BCHK: begin
				ft_we = (ft_rd_q == '0);
				ft_wdata = i_q[NUM_W-1:0];
				pl_we = (ft_rd_q == '0) && (pc_q < cnt_t'(PRIME_SLOTS));
			end
			S_BCMP: begin
				ft_waddr = m_q[NUM_W-1:0];
				ft_wdata = j_q;
				ft_we = !(j_q > lpf_q) && (m_q < PROD_W'(lim));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ft_we)
			ft_mem[ft_waddr] <= ft_wdata;
		ft_rd_q <= ft_mem[ft_raddr];
		if (pl_we)
			pl_mem[pc_q[PL_AW-1:0]] <= i_q[NUM_W-1:0];
		pl_rd_q <= pl_mem[k_q[PL_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= lim_t'(MAX_LIMIT);
			pc_q <= '0;
			built_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (res.ready && !emit_go)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						n_q <= cmd.number;
						pr_pf_q <= '0;
						pr_ex_q <= '0;
						pr_lf_q <= '0;
						pr_ip_q <= 1'b0;
						pr_err_q <= 1'b0;
						pr_last_q <= 1'b1;
						if (mode_t'(cmd.mode) == MODE_BUILD) begin
							i_q <= '0;
							built_q <= 1'b0;
							state_q <= S_CLR;
						end else if (!built_q || {1'b0, cmd.number} >= lim) begin
							pr_err_q <= 1'b1;
							state_q <= S_EMIT;
						end else if (cmd.number < num_t'(2)) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_QRD;
						end
					end
				end
				// clear sweep, i_q doubles as the address
				S_CLR: begin
					if (i_q == lim_t'(MAX_LIMIT - 1)) begin
						pc_q <= '0;
						i_q <= lim_t'(2);
						state_q <= (lim_t'(2) < lim) ? S_BRD : S_EMIT;
						built_q <= (lim_t'(2) >= lim);
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_BRD: state_q <= S_BCHK;
				S_BCHK: begin
					k_q <= '0;
					if (ft_rd_q == '0) begin
						lpf_q <= i_q[NUM_W-1:0];
						if (pc_q < cnt_t'(PRIME_SLOTS))
							pc_q <= pc_q + 1'b1;
					end else begin
						lpf_q <= ft_rd_q;
					end
					state_q <= S_BPL;
				end
				S_BPL: begin
					if (k_q >= pc_q) begin
						if (i_q + 1'b1 >= lim) begin
							built_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_BRD;
						end
					end else begin
						state_q <= S_BPW;
					end
				end
				S_BPW: state_q <= S_BMUL;
				S_BMUL: begin
					j_q <= pl_rd_q;
					m_q <= PROD_W'(i_q) * PROD_W'(pl_rd_q);
					state_q <= S_BCMP;
				end
				S_BCMP: begin
					if (j_q > lpf_q || m_q >= PROD_W'(lim)) begin
						if (i_q + 1'b1 >= lim) begin
							built_q <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_BRD;
						end
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_BPL;
					end
				end
				S_QRD: state_q <= S_QFIRST;
				S_QFIRST: begin
					if (ft_rd_q == '0) begin
						// limit raised since the last build
						pr_err_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						lf_q <= ft_rd_q;
						ip_q <= (ft_rd_q == n_q);
						v_q <= ft_rd_q;
						pf_q <= ft_rd_q;
						ex_q <= '0;
						rc_q <= '0;
						state_q <= S_QLOOP;
					end
				end
				S_QLOOP: begin
					if (div_start) begin
						state_q <= S_QDIV;
					end else begin
						pr_pf_q <= pf_q;
						pr_ex_q <= ex_q;
						pr_lf_q <= lf_q;
						pr_ip_q <= ip_q;
						pr_last_q <= (n_q <= num_t'(1)) || (rc_q == RES_W'(MAX_RES - 1))
							|| (v_q < num_t'(2));
						pf_q <= v_q;
						ex_q <= '0;
						rc_q <= rc_q + 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_QDIV: begin
					if (div_done) begin
						n_q <= div_quo;
						if (ex_q != '1)
							ex_q <= ex_q + 1'b1;
						state_q <= S_QNRD;
					end
				end
				S_QNRD: state_q <= S_QNV;
				S_QNV: begin
					v_q <= ft_rd_q;
					state_q <= S_QLOOP;
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						res.prime_factor <= pr_pf_q;
						res.exponent <= pr_ex_q;
						res.least_factor <= pr_lf_q;
						res.prime_flag <= pr_ip_q;
						res.prime_count <= pc_q;
						res.error <= pr_err_q;
						res.last <= pr_last_q;
						state_q <= pr_last_q ? S_IDLE : S_QLOOP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = ov_q;

endmodule

// File: rtl/core/lpfs_checker.sv
// Port-level assertions for the sieve factorizer, bound to the top level.
module lpfs_checker
	import lpfs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input num_t prime_factor,
	input exp_t exponent,
	input num_t least_factor,
	input logic prime_flag,
	input logic error,
	input logic last
);

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error |-> last && prime_factor == '0 && exponent == '0)
		else $error("error result not final or carries a factor");

	a_mid_factor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last |-> prime_factor >= num_t'(2) && exponent != '0 && !error)
		else $error("intermediate result without a factor");

	a_prime: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && prime_flag |-> last && prime_factor == least_factor
		&& exponent == exp_t'(1))
		else $error("prime query result inconsistent");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

endmodule

bind least_prime_factor_sieve_factorizer lpfs_checker u_lpfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.prime_factor (res.prime_factor),
	.exponent     (res.exponent),
	.least_factor (res.least_factor),
	.prime_flag   (res.prime_flag),
	.error        (res.error),
	.last         (res.last)
);
